// ===== hdl/binary_frame_parser_crc16_macros.svh =====
// Assertion macros for the binary frame parser.
`ifndef BINARY_FRAME_PARSER_CRC16_MACROS_SVH
`define BINARY_FRAME_PARSER_CRC16_MACROS_SVH

`ifndef SYNTH
`define BFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define BFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFP_ASSERT(lbl, clk, rstn, prop, msg)
`define BFP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/bfp_pkg.sv =====
// Package with phase codes, constants and CRC step for the binary frame parser.
`default_nettype none

package bfp_pkg;

    localparam logic [7:0]  PREAMBLE = 8'h55;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int USER_PAYLOAD = 0;
    localparam int USER_DONE    = 1;
    localparam int USER_JUNK    = 2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_SENDER = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [6:0]  pad;
        logic [7:0]  frame_length;
        logic [15:0] frame_sender;
        logic [15:0] frame_type;
        logic        crc_ok;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
    } result_data_t;

    typedef struct packed {
        logic junk_byte;
        logic frame_done;
        logic payload_valid;
    } result_user_t;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/binary_frame_parser_crc16.sv =====
// Top level of the binary frame parser with CRC-16-CCITT check.
//
// channel  | dir | data            | user
// s_axis   | in  | 8b stream byte  | -
// m_axis   | out | 64b result data | 3b result flags
//
// One result per input byte; one byte per cycle sustained while m_axis accepts results.
// Pipeline: input register then result register; each result is registered in both before it is valid.
// The CRC step is an 8-bit unrolled update between the two registers.
// rst_n returns the parser to preamble hunt and empties both registers.
// A stalled m_axis holds the result; s_axis takes at most one more byte, into the input register.
`default_nettype none

`include "binary_frame_parser_crc16_macros.svh"

module binary_frame_parser_crc16
    import bfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [16] crc_ok, [32:17] frame_type,
    // [48:33] frame_sender, [56:49] frame_length, [63:57] zero
    output      logic [63:0] m_axis_tdata,
    // [0] payload_valid, [1] frame_done, [2] junk_byte
    output      logic [2:0]  m_axis_tuser
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    result_data_t out_data_reg;
    result_user_t out_user_reg;

    phase_t       phase_reg,  phase_next;
    logic [7:0]   count_reg,  count_next;
    logic [15:0]  type_reg,   type_next;
    logic [15:0]  sender_reg, sender_next;
    logic [7:0]   length_reg, length_next;
    logic [15:0]  crc_reg,    crc_next;
    logic [15:0]  rcrc_reg,   rcrc_next;

    result_data_t res_data;
    result_user_t res_user;
    logic [15:0]  crc_upd;
    logic [7:0]   count_inc;
    logic         out_en;
    logic         advance;

    assign out_en        = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_en;
    assign s_axis_tready = !in_valid_reg || out_en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign crc_upd   = crc16_step(crc_reg, in_byte_reg);
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        type_next   = type_reg;
        sender_next = sender_reg;
        length_next = length_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        res_data    = '0;
        res_user    = '0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte_reg == PREAMBLE)
                begin
                    phase_next = PH_TYPE;
                    count_next = '0;
                    crc_next   = '0;
                end
                else
                begin
                    res_user.junk_byte = 1'b1;
                end
            end
            PH_TYPE:
            begin
                crc_next = crc_upd;
                if (count_reg == 8'd0)
                begin
                    type_next  = {type_reg[15:8], in_byte_reg};
                    count_next = 8'd1;
                end
                else
                begin
                    type_next  = {in_byte_reg, type_reg[7:0]};
                    count_next = '0;
                    phase_next = PH_SENDER;
                end
            end
            PH_SENDER:
            begin
                crc_next = crc_upd;
                if (count_reg == 8'd0)
                begin
                    sender_next = {sender_reg[15:8], in_byte_reg};
                    count_next  = 8'd1;
                end
                else
                begin
                    sender_next = {in_byte_reg, sender_reg[7:0]};
                    count_next  = '0;
                    phase_next  = PH_LEN;
                end
            end
            PH_LEN:
            begin
                crc_next    = crc_upd;
                length_next = in_byte_reg;
                count_next  = '0;
                phase_next  = (in_byte_reg == 8'd0) ? PH_CRC : PH_DATA;
            end
            PH_DATA:
            begin
                crc_next               = crc_upd;
                res_user.payload_valid = 1'b1;
                res_data.payload_byte  = in_byte_reg;
                res_data.payload_index = count_reg;
                if (count_inc >= length_reg)
                begin
                    count_next = '0;
                    phase_next = PH_CRC;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_CRC:
            begin
                if (count_reg == 8'd0)
                begin
                    rcrc_next  = {rcrc_reg[15:8], in_byte_reg};
                    count_next = 8'd1;
                end
                else
                begin
                    rcrc_next             = {in_byte_reg, rcrc_reg[7:0]};
                    count_next            = '0;
                    phase_next            = PH_HUNT;
                    res_user.frame_done   = 1'b1;
                    res_data.crc_ok       = ({in_byte_reg, rcrc_reg[7:0]} == crc_reg);
                    res_data.frame_type   = type_reg;
                    res_data.frame_sender = sender_reg;
                    res_data.frame_length = length_reg;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            type_reg      <= '0;
            sender_reg    <= '0;
            length_reg    <= '0;
            crc_reg       <= '0;
            rcrc_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_en)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                type_reg   <= type_next;
                sender_reg <= sender_next;
                length_reg <= length_next;
                crc_reg    <= crc_next;
                rcrc_reg   <= rcrc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
    end

    `BFP_ASSERT(a_done_hunts, clk, rst_n, (m_axis_tvalid && m_axis_tuser[USER_DONE]) |-> (phase_reg == PH_HUNT), "frame_done without return to hunt")
    `BFP_ASSERT(a_junk_hunts, clk, rst_n, (m_axis_tvalid && m_axis_tuser[USER_JUNK]) |-> (phase_reg == PH_HUNT), "junk byte outside hunt")
    `BFP_ASSERT(a_payload_phase, clk, rst_n, (m_axis_tvalid && m_axis_tuser[USER_PAYLOAD]) |-> (phase_reg == PH_DATA || phase_reg == PH_CRC), "payload result in wrong phase")
    `BFP_ASSERT(a_payload_index, clk, rst_n, (m_axis_tvalid && m_axis_tuser[USER_PAYLOAD]) |-> (m_axis_tdata[15:8] < length_reg), "payload index beyond length")

endmodule

`default_nettype wire
